// ===== rtl/core/form_field_extract_decode_defines.svh =====
// assertion macros for the form field extract and decode block
`ifndef FORM_FIELD_EXTRACT_DECODE_DEFINES_SVH
`define FORM_FIELD_EXTRACT_DECODE_DEFINES_SVH
`ifndef SYNTHESIS
`define FFD_ASSERT(name, clk, rst, expr, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define FFD_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define FFD_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define FFD_ASSERT(name, clk, rst, expr, msg)
`define FFD_ASSERT_IMP(name, clk, rst, ante, cons, msg)
`define FFD_ASSERT_NXT(name, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/core/ffd_pkg.sv =====
// types, constants and codes shared by the form field decode block
package ffd_pkg;

   localparam int KEY_BYTES    = 16;
   localparam int MAX_CAPACITY = 256;

   localparam int KEY_IDX_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
   localparam int NAME_W    = 5;
   localparam logic [NAME_W-1:0] NAME_MAX = '1;
   localparam logic [NAME_W-1:0] KEY_BYTES_N = NAME_W'(KEY_BYTES);

   localparam int CAP_W     = 9;
   localparam int CAP_LIM_I = (MAX_CAPACITY > (2 ** CAP_W) - 1) ? (2 ** CAP_W) - 1 : MAX_CAPACITY;
   localparam logic [CAP_W-1:0] CAP_LIMIT = CAP_W'(CAP_LIM_I);

   localparam int RES_MAX   = 3;
   localparam int RES_CNT_W = $clog2(RES_MAX + 1);
   localparam int Q_DEPTH   = 4;
   localparam int PTR_W     = $clog2(Q_DEPTH);
   localparam int CNT_W     = $clog2(Q_DEPTH + 1);

   // register indexes
   localparam logic [1:0] CSR_KEY_LOW  = 2'd0;
   localparam logic [1:0] CSR_KEY_HIGH = 2'd1;
   localparam logic [1:0] CSR_KEY_LEN  = 2'd2;
   localparam logic [1:0] CSR_CAPACITY = 2'd3;

   // status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_BAD_HEX   = 2'd2;
   localparam logic [1:0] ST_TOO_LONG  = 2'd3;

   // escape progress
   localparam logic [1:0] ESC_NONE = 2'd0;
   localparam logic [1:0] ESC_PCT  = 2'd1;
   localparam logic [1:0] ESC_HELD = 2'd2;

   // characters
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_PCT   = 8'h25;
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UF    = 8'h46;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LF    = 8'h66;

   typedef enum logic [3:0] {
      PH_NAME  = 4'b0001,
      PH_SKIP  = 4'b0010,
      PH_VALUE = 4'b0100,
      PH_DONE  = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [15:0][7:0]  key;
      logic [NAME_W-1:0] key_length;
      logic [CAP_W-1:0]  capacity;
   } cfg_type;

   typedef struct packed {
      phase_type         phase;
      logic [NAME_W-1:0] name_count;
      logic              name_mismatch;
      logic [1:0]        escape_pending;
      logic [7:0]        held_digit;
      logic [CAP_W-1:0]  written_count;
   } state_type;

   typedef struct packed {
      logic       is_status;
      logic [7:0] value_byte;
      logic [1:0] status_code;
      logic       run_last;
   } result_type;

   typedef struct packed {
      result_type [RES_MAX-1:0] res;
      logic [RES_CNT_W-1:0]     n;
   } step_out_type;

   typedef struct packed {
      state_type  st;
      result_type res;
      logic       ok;
   } emit_type;

endpackage

// ===== rtl/core/ffd_req_if.sv =====
// body byte channel
interface ffd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] body_byte;
   logic       body_last;

   modport source (output valid, output body_byte, output body_last, input ready);
   modport sink (input valid, input body_byte, input body_last, output ready);
endinterface

// ===== rtl/core/ffd_rsp_if.sv =====
// decoded result channel
interface ffd_rsp_if;
   logic       valid;
   logic       ready;
   logic       is_status;
   logic [7:0] value_byte;
   logic [1:0] status_code;
   logic       run_last;

   modport source (output valid, output is_status, output value_byte, output status_code,
                   output run_last, input ready);
   modport sink (input valid, input is_status, input value_byte, input status_code,
                 input run_last, output ready);
endinterface

// ===== rtl/core/form_field_extract_decode.sv =====
// top level of the form field extract and decode block
//
// Usage: the body of an url-encoded form enters one byte per item on req_ch
// (body_byte, body_last); a zero byte or body_last closes the body. The key
// and the output capacity are set on the csr_ write port while the block is
// idle. Results leave on rsp_ch: decoded value bytes of the first field whose
// name matches the key, then one closing status per body. run_last marks the
// last result that one byte item caused; a byte may cause none to three.
// Timing: a byte is held in the input register, and its results pass through
// the result queue before they are offered on rsp_ch.
// Throughput: one byte per cycle while each byte gives at most one result and
// rsp_ch.ready stays high; the result port drains one result per cycle, so
// bytes that give two or three results hold req_ch.ready low until the
// four-entry result queue has room for three more.
// When the receiver stalls, results wait in the queue and the input register
// takes one more byte before ready drops.
// Reset (synchronous) empties the queue, drops the input register, returns
// the parser to the name part and loads key length 0 and capacity 256.
`include "form_field_extract_decode_defines.svh"
module form_field_extract_decode import ffd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_we,
   input  logic [1:0]    csr_index,
   input  logic [63:0]   csr_wdata,
   ffd_req_if.sink       req_ch,
   ffd_rsp_if.source     rsp_ch
);

   cfg_type      cfg_ff;
   state_type    state_ff, state_in;
   logic         in_valid_ff;
   logic [7:0]   in_byte_ff;
   logic         in_last_ff;
   logic         process;
   logic         req_take;
   step_out_type step_out;
   step_out_type push;
   result_type   head;
   logic [CNT_W-1:0] q_count;
   logic         pop;

   // room for the most results one byte can give
   assign process = in_valid_ff && (q_count <= CNT_W'(Q_DEPTH - RES_MAX));
   assign req_ch.ready = !in_valid_ff || process;
   assign req_take = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.key <= '0;
         cfg_ff.key_length <= '0;
         cfg_ff.capacity <= CAP_W'(256);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_KEY_LOW:  cfg_ff.key[7:0] <= csr_wdata;
            CSR_KEY_HIGH: cfg_ff.key[15:8] <= csr_wdata;
            CSR_KEY_LEN:  cfg_ff.key_length <= csr_wdata[NAME_W-1:0];
            CSR_CAPACITY: cfg_ff.capacity <= csr_wdata[CAP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (process) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_ch.body_byte;
         in_last_ff <= req_ch.body_last;
      end
   end

   ffd_step u_step (
      .body_byte (in_byte_ff),
      .body_last (in_last_ff),
      .cfg       (cfg_ff),
      .cur       (state_ff),
      .nxt       (state_in),
      .out       (step_out)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase <= PH_NAME;
         state_ff.name_count <= '0;
         state_ff.name_mismatch <= 1'b0;
         state_ff.escape_pending <= ESC_NONE;
         state_ff.held_digit <= '0;
         state_ff.written_count <= '0;
      end else if (process) begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      push.res = step_out.res;
      push.n = process ? step_out.n : '0;
   end

   assign pop = rsp_ch.valid && rsp_ch.ready;

   ffd_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .count (q_count)
   );

   assign rsp_ch.valid = (q_count != '0);
   assign rsp_ch.is_status = head.is_status;
   assign rsp_ch.value_byte = head.value_byte;
   assign rsp_ch.status_code = head.status_code;
   assign rsp_ch.run_last = head.run_last;

   `FFD_ASSERT(a_queue_bound, clock, reset, q_count <= CNT_W'(Q_DEPTH), "result queue overfull")
   `FFD_ASSERT(a_no_overflow, clock, reset, ({1'b0, q_count} + (CNT_W+1)'(push.n)) <= (CNT_W+1)'(Q_DEPTH), "push would overflow result queue")
   `FFD_ASSERT_IMP(a_rest_queued, clock, reset, rsp_ch.valid && !rsp_ch.run_last, q_count >= CNT_W'(2), "item results split across cycles")
   `FFD_ASSERT_NXT(a_push_shows, clock, reset, push.n != '0, rsp_ch.valid, "pushed result not offered")

endmodule

// ===== rtl/core/ffd_step.sv =====
// per-byte parse and decode step: next state and up to three results
module ffd_step import ffd_pkg::*; (
   input  logic [7:0]   body_byte,
   input  logic         body_last,
   input  cfg_type      cfg,
   input  state_type    cur,
   output state_type    nxt,
   output step_out_type out
);

   function automatic logic [4:0] hex_val(logic [7:0] c);
      logic [4:0] v;
      v = '0;
      if (c >= CH_0 && c <= CH_9) v = {1'b1, 4'(c - CH_0)};
      else if (c >= CH_UA && c <= CH_UF) v = {1'b1, 4'(c - CH_UA + 8'd10)};
      else if (c >= CH_LA && c <= CH_LF) v = {1'b1, 4'(c - CH_LA + 8'd10)};
      return v;
   endfunction

   function automatic result_type status_res(logic [1:0] code);
      result_type r;
      r = '0;
      r.is_status = 1'b1;
      r.status_code = code;
      return r;
   endfunction

   function automatic logic [7:0] plain(logic [7:0] c);
      return (c == CH_PLUS) ? CH_SPACE : c;
   endfunction

   // one value byte, or too-long status once written_count + 1 reaches the capacity
   function automatic emit_type emit(state_type s, logic [7:0] v, logic [CAP_W-1:0] cap);
      emit_type e;
      logic [CAP_W:0] need;
      need = {1'b0, s.written_count} + (CAP_W+1)'(1);
      e.st = s;
      e.res = '0;
      if (need < {1'b0, cap}) begin
         e.ok = 1'b1;
         e.res.value_byte = v;
         e.st.written_count = s.written_count + CAP_W'(1);
      end else begin
         e.ok = 1'b0;
         e.res = status_res(ST_TOO_LONG);
         e.st.phase = PH_DONE;
      end
      return e;
   endfunction

   always_comb begin
      state_type s;
      result_type [RES_MAX-1:0] r;
      logic [RES_CNT_W-1:0] n;
      logic [CAP_W-1:0] cap;
      logic [4:0] hi;
      logic [4:0] lo;
      logic do_close;
      logic end_body;
      logic [1:0] esc;
      emit_type e;

      s = cur;
      r = '0;
      n = '0;
      do_close = 1'b0;
      cap = (cfg.capacity > CAP_LIMIT) ? CAP_LIMIT : cfg.capacity;
      hi = hex_val(cur.held_digit);
      lo = hex_val(body_byte);
      end_body = (body_byte == 8'd0) || body_last;
      e = '0;

      if (body_byte != 8'd0) begin
         unique case (cur.phase)
            PH_NAME: begin
               if (body_byte == CH_AMP) begin
                  s.name_count = '0;
                  s.name_mismatch = 1'b0;
               end else if (body_byte == CH_EQ) begin
                  if (!cur.name_mismatch && cur.name_count == cfg.key_length) begin
                     s.phase = PH_VALUE;
                     s.written_count = '0;
                     s.escape_pending = ESC_NONE;
                  end else begin
                     s.phase = PH_SKIP;
                  end
               end else begin
                  if (cur.name_count >= KEY_BYTES_N ||
                      cfg.key[cur.name_count[KEY_IDX_W-1:0]] != body_byte)
                     s.name_mismatch = 1'b1;
                  if (cur.name_count != NAME_MAX)
                     s.name_count = cur.name_count + NAME_W'(1);
               end
            end
            PH_SKIP: begin
               if (body_byte == CH_AMP) begin
                  s.phase = PH_NAME;
                  s.name_count = '0;
                  s.name_mismatch = 1'b0;
               end
            end
            PH_VALUE: begin
               if (body_byte == CH_AMP) begin
                  do_close = 1'b1;
               end else begin
                  case (cur.escape_pending)
                     ESC_NONE: begin
                        if (body_byte == CH_PCT) begin
                           s.escape_pending = ESC_PCT;
                        end else begin
                           e = emit(s, plain(body_byte), cap);
                           s = e.st;
                           r[n] = e.res;
                           n = n + RES_CNT_W'(1);
                        end
                     end
                     ESC_PCT: begin
                        s.held_digit = body_byte;
                        s.escape_pending = ESC_HELD;
                     end
                     default: begin
                        s.escape_pending = ESC_NONE;
                        if (!hi[4] || !lo[4]) begin
                           r[n] = status_res(ST_BAD_HEX);
                           n = n + RES_CNT_W'(1);
                           s.phase = PH_DONE;
                        end else begin
                           e = emit(s, {hi[3:0], lo[3:0]}, cap);
                           s = e.st;
                           r[n] = e.res;
                           n = n + RES_CNT_W'(1);
                        end
                     end
                  endcase
               end
            end
            PH_DONE: begin
            end
            default: begin
            end
         endcase
      end

      if (end_body && (s.phase == PH_NAME || s.phase == PH_SKIP)) begin
         r[n] = status_res(ST_NOT_FOUND);
         n = n + RES_CNT_W'(1);
         s.phase = PH_DONE;
      end else if (end_body && s.phase == PH_VALUE) begin
         do_close = 1'b1;
      end

      // close of the value: a dangling escape goes out as '%' and any held character
      if (do_close) begin
         esc = s.escape_pending;
         e.ok = 1'b1;
         if (esc != ESC_NONE) begin
            e = emit(s, CH_PCT, cap);
            s = e.st;
            r[n] = e.res;
            n = n + RES_CNT_W'(1);
            if (e.ok && esc == ESC_HELD) begin
               e = emit(s, plain(s.held_digit), cap);
               s = e.st;
               r[n] = e.res;
               n = n + RES_CNT_W'(1);
            end
         end
         if (e.ok) begin
            s.escape_pending = ESC_NONE;
            r[n] = status_res(ST_OK);
            n = n + RES_CNT_W'(1);
            s.phase = PH_DONE;
         end
      end

      if (end_body) begin
         s.phase = PH_NAME;
         s.name_count = '0;
         s.name_mismatch = 1'b0;
         s.escape_pending = ESC_NONE;
         s.held_digit = '0;
         s.written_count = '0;
      end

      for (int i = 0; i < RES_MAX; i++)
         r[i].run_last = (RES_CNT_W'(i + 1) == n);

      nxt = s;
      out.res = r;
      out.n = n;
   end

endmodule

// ===== rtl/core/ffd_queue.sv =====
// small result queue that takes up to three results in one cycle
module ffd_queue import ffd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  step_out_type     push,
   input  logic             pop,
   output result_type       head,
   output logic [CNT_W-1:0] count
);

   result_type [Q_DEPTH-1:0] q_ff;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push.n);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in = count_ff + CNT_W'(push.n) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < RES_MAX; i++)
         if (RES_CNT_W'(i) < push.n)
            q_ff[wr_ptr_ff + PTR_W'(i)] <= push.res[i];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   assign head = q_ff[rd_ptr_ff];
   assign count = count_ff;

endmodule
